/* src/bsg_pkg.sv */
// Shared widths and types for the bounding sphere grow-by-point block.
package bsg_pkg;

  localparam int unsigned CoordBits = 32;
  localparam int unsigned RadBits   = CoordBits - 1;
  localparam int unsigned DiffBits  = CoordBits + 1;
  localparam int unsigned SqBits    = 2 * CoordBits + 2;
  localparam int unsigned RootBits  = CoordBits + 1;
  localparam int unsigned ProdBits  = 2 * DiffBits;
  localparam int unsigned StepBits  = 7;

  typedef enum logic [1:0] {
    OP_SQRT = 2'd0,
    OP_DIV  = 2'd1
  } op_e;

  typedef struct packed {
    logic                start;
    op_e                 op;
    logic [SqBits-1:0]   num;
    logic [RootBits-1:0] den;
  } iter_req_t;

  typedef struct packed {
    logic                done;
    logic [RootBits-1:0] res;
    logic                exact;
  } iter_rsp_t;

endpackage

/* src/bsg_iter.sv */
// Shared bit-serial unit: square root and division, one result bit a cycle.
module bsg_iter (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  bsg_pkg::iter_req_t req_i,
  output bsg_pkg::iter_rsp_t rsp_o
);
  import bsg_pkg::*;

  logic                busy_q, busy_d;
  op_e                 op_q, op_d;
  logic [StepBits-1:0] cnt_q, cnt_d;
  logic [SqBits-1:0]   num_q, num_d;
  logic [RootBits-1:0] den_q, den_d;
  logic [SqBits+1:0]   rem_q, rem_d;
  logic [RootBits-1:0] res_q, res_d;
  logic [SqBits+1:0]   trial;
  logic [SqBits+1:0]   shifted;

  always_comb begin
    busy_d = busy_q;
    op_d   = op_q;
    cnt_d  = cnt_q;
    num_d  = num_q;
    den_d  = den_q;
    rem_d  = rem_q;
    res_d  = res_q;
    shifted = '0;
    trial   = '0;
    if (req_i.start) begin
      busy_d = 1'b1;
      op_d   = req_i.op;
      num_d  = req_i.num;
      den_d  = req_i.den;
      rem_d  = '0;
      res_d  = '0;
      cnt_d  = (req_i.op == OP_SQRT) ? StepBits'(SqBits / 2) : StepBits'(SqBits);
    end else if (busy_q) begin
      case (op_q)
        OP_SQRT: begin
          // Restoring square root: two radicand bits enter each step.
          shifted = {rem_q[SqBits-1:0], num_q[SqBits-1 -: 2]};
          trial   = shifted - {{(SqBits+2-RootBits-2){1'b0}}, res_q, 2'b01};
          num_d   = {num_q[SqBits-3:0], 2'b00};
          if (!trial[SqBits+1]) begin
            rem_d = trial;
            res_d = {res_q[RootBits-2:0], 1'b1};
          end else begin
            rem_d = shifted;
            res_d = {res_q[RootBits-2:0], 1'b0};
          end
        end
        OP_DIV: begin
          shifted = {rem_q[SqBits:0], num_q[SqBits-1]};
          trial   = shifted - {{(SqBits+2-RootBits){1'b0}}, den_q};
          num_d   = {num_q[SqBits-2:0], 1'b0};
          if (!trial[SqBits+1]) begin
            rem_d = trial;
            res_d = {res_q[RootBits-2:0], 1'b1};
          end else begin
            rem_d = shifted;
            res_d = {res_q[RootBits-2:0], 1'b0};
          end
        end
        default: begin
          rem_d = rem_q;
        end
      endcase
      cnt_d = cnt_q - StepBits'(1);
      if (cnt_q == StepBits'(1)) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q  <= op_d;
    num_q <= num_d;
    den_q <= den_d;
    rem_q <= rem_d;
    res_q <= res_d;
  end

  logic busy_p_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) busy_p_q <= 1'b0;
    else         busy_p_q <= busy_q;
  end

  assign rsp_o.done  = busy_p_q && !busy_q;
  assign rsp_o.res   = res_q;
  assign rsp_o.exact = (rem_q == '0);
endmodule

/* src/bounding_sphere_grow_by_point.sv */
// Top level of the bounding sphere grow-by-point block.
//
//  channel | valid    | stall    | payload
//  --------+----------+----------+---------------------------------------------
//  input   | valid_i  | stall_o  | point_x_i, point_y_i, point_z_i, start_new_i
//  output  | valid_o  | stall_i  | center_*_out_o, radius_out_o, grew_o
//
// A start point or a point inside the sphere passes through difference, three
// squares, compare, output and idle before the next word is accepted. A point
// that grows the sphere also runs the shared bit-serial unit: a 33-step square
// root, a radius step, then three 66-step divisions, one per axis, each after
// its multiply step.
// Reset clears the sequencer, the output valid and the sphere valid flag; no
// clearing pass. The result word waits in an output register while the next word
// is taken; only the next result waits for that register to be emptied.
module bounding_sphere_grow_by_point (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                valid_i,
  output logic                                stall_o,
  input  logic signed [bsg_pkg::CoordBits-1:0] point_x_i,
  input  logic signed [bsg_pkg::CoordBits-1:0] point_y_i,
  input  logic signed [bsg_pkg::CoordBits-1:0] point_z_i,
  input  logic                                start_new_i,
  output logic                                valid_o,
  input  logic                                stall_i,
  output logic signed [bsg_pkg::CoordBits-1:0] center_x_out_o,
  output logic signed [bsg_pkg::CoordBits-1:0] center_y_out_o,
  output logic signed [bsg_pkg::CoordBits-1:0] center_z_out_o,
  output logic        [bsg_pkg::RadBits-1:0]   radius_out_o,
  output logic                                grew_o
);
  import bsg_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_DIFF  = 9'b000000010,
    S_SQ    = 9'b000000100,
    S_CMP   = 9'b000001000,
    S_ROOT  = 9'b000010000,
    S_RAD   = 9'b000100000,
    S_MUL   = 9'b001000000,
    S_DIV   = 9'b010000000,
    S_OUT   = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  logic signed [CoordBits-1:0] cx_q, cy_q, cz_q;
  logic        [RadBits-1:0]   rad_q;
  logic                        sv_q;
  logic signed [CoordBits-1:0] px_q, py_q, pz_q;
  logic signed [DiffBits-1:0]  dx_q, dy_q, dz_q;
  logic        [1:0]           ax_q;
  logic        [SqBits-1:0]    acc_q;
  logic        [RootBits-1:0]  d_q;
  logic        [RootBits-1:0]  rn_q;
  logic                        ovalid_q, grew_q;

  iter_req_t req;
  iter_rsp_t rsp;

  bsg_iter u_iter (.clk_i(clk_i), .rst_ni(rst_ni), .req_i(req), .rsp_o(rsp));

  // Per-axis selection of the current delta, its magnitude and the centre coordinate.
  logic signed [DiffBits-1:0] dsel;
  logic        [DiffBits-1:0] amag;
  logic signed [CoordBits-1:0] csel;
  always_comb begin
    case (ax_q)
      2'd0:    begin dsel = dx_q; csel = cx_q; end
      2'd1:    begin dsel = dy_q; csel = cy_q; end
      default: begin dsel = dz_q; csel = cz_q; end
    endcase
    amag = dsel[DiffBits-1] ? DiffBits'(-dsel) : DiffBits'(dsel);
  end

  logic [ProdBits-1:0] sq_prod;
  assign sq_prod = amag * amag;

  logic [SqBits-1:0] rsq;
  assign rsq = SqBits'(rad_q) * SqBits'(rad_q);

  logic [RootBits+1:0] rn_sum;
  assign rn_sum = (RootBits+2)'(rad_q) + (RootBits+2)'(rsp.res + RootBits'(!rsp.exact))
                  + (RootBits+2)'(1);

  // The numerator for this axis's division, |delta| * (d - new radius).
  logic [ProdBits-1:0] mv_prod;
  assign mv_prod = amag * DiffBits'(d_q - rn_q);

  // The quotient is the move along this axis, towards the point.
  logic signed [DiffBits:0] cwide, owide, newc;
  assign cwide = (DiffBits+1)'(csel);
  assign owide = signed'((DiffBits+1)'(rsp.res));
  assign newc  = dsel[DiffBits-1] ? cwide - owide : cwide + owide;

  always_comb begin
    state_d   = state_q;
    req.start = 1'b0;
    req.op    = OP_SQRT;
    req.num   = acc_q;
    req.den   = d_q;
    case (state_q)
      S_IDLE:  if (valid_i) state_d = S_DIFF;
      S_DIFF:  state_d = S_SQ;
      S_SQ:    if (ax_q == 2'd2) state_d = S_CMP;
      S_CMP: begin
        if (acc_q <= rsq) state_d = S_OUT;
        else begin
          state_d   = S_ROOT;
          req.start = 1'b1;
        end
      end
      S_ROOT:  if (rsp.done) state_d = S_RAD;
      S_RAD:   state_d = S_MUL;
      S_MUL: begin
        state_d   = S_DIV;
        req.start = 1'b1;
        req.op    = OP_DIV;
        req.num   = SqBits'(mv_prod);
      end
      S_DIV:   if (rsp.done) state_d = (ax_q == 2'd2) ? S_OUT : S_MUL;
      S_OUT:   if (!ovalid_q || !stall_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      sv_q     <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_IDLE && valid_i && (!sv_q || start_new_i)) sv_q <= 1'b1;
      if (state_q == S_OUT && (!ovalid_q || !stall_i)) ovalid_q <= 1'b1;
      else if (ovalid_q && !stall_i)                   ovalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: if (valid_i) begin
        px_q <= point_x_i; py_q <= point_y_i; pz_q <= point_z_i;
        grew_q <= !sv_q || start_new_i;
        if (!sv_q || start_new_i) begin
          // New sphere at the point; it goes straight out via the compare.
          cx_q <= point_x_i; cy_q <= point_y_i; cz_q <= point_z_i;
          rad_q <= '0;
        end
      end
      S_DIFF: begin
        dx_q <= DiffBits'(px_q) - DiffBits'(cx_q);
        dy_q <= DiffBits'(py_q) - DiffBits'(cy_q);
        dz_q <= DiffBits'(pz_q) - DiffBits'(cz_q);
        ax_q <= 2'd0;
        acc_q <= '0;
      end
      S_SQ: begin
        acc_q <= acc_q + SqBits'(sq_prod);
        ax_q  <= (ax_q == 2'd2) ? 2'd0 : ax_q + 2'd1;
      end
      S_RAD: begin
        d_q  <= rsp.res + RootBits'(!rsp.exact);
        rn_q <= rn_sum[RootBits:1];
        rad_q <= (rn_sum[RootBits+1:1] > (RootBits+1)'({RadBits{1'b1}}))
                 ? {RadBits{1'b1}} : RadBits'(rn_sum[RootBits+1:1]);
        grew_q <= 1'b1;
      end
      S_DIV: if (rsp.done) begin
        // Move this axis of the centre, then go on to the next axis.
        case (ax_q)
          2'd0:    cx_q <= CoordBits'(newc);
          2'd1:    cy_q <= CoordBits'(newc);
          default: cz_q <= CoordBits'(newc);
        endcase
        ax_q <= ax_q + 2'd1;
      end
      S_OUT: if (!ovalid_q || !stall_i) begin
        center_x_out_o <= cx_q; center_y_out_o <= cy_q; center_z_out_o <= cz_q;
        radius_out_o   <= rad_q; grew_o <= grew_q;
      end
      default: ;
    endcase
  end

  assign stall_o = (state_q != S_IDLE);
  assign valid_o = ovalid_q;
endmodule

/* src/bsg_checker.sv */
// Port-level checks for the bounding sphere block, bound to the top level.
module bsg_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              valid_i,
  input logic                              stall_o,
  input logic                              valid_o,
  input logic                              stall_i,
  input logic [bsg_pkg::RadBits-1:0]       radius_out_o,
  input logic                              grew_o
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && stall_i |=> valid_o && $stable(radius_out_o) && $stable(grew_o))
    else $error("result word changed while stalled");

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && !stall_o |=> stall_o)
    else $error("input taken twice in a row");

  a_outstall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(valid_o) |-> !stall_o)
    else $error("result appeared while the block was still busy");
endmodule

bind bounding_sphere_grow_by_point bsg_checker u_bsg_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .valid_i(valid_i), .stall_o(stall_o),
  .valid_o(valid_o), .stall_i(stall_i), .radius_out_o(radius_out_o), .grew_o(grew_o)
);
